/* sv/bss_pkg.sv */
package bss_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int TEXT_MAX    = 65536;
    localparam int PAT_LEN_W   = $clog2(PATTERN_MAX + 1);
    localparam int TEXT_POS_W  = $clog2(TEXT_MAX + 1);
    localparam int INDEX_W     = 16;

    typedef enum logic {
        FUNC_PATTERN = 1'b0,
        FUNC_TEXT    = 1'b1
    } t_func;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       is_last;
    } t_req;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] start_index;
        logic               pattern_overflow;
    } t_rsp;

    typedef struct packed {
        logic clr;
        logic pat_shift;
        logic txt_shift;
    } t_cell_ctrl;

endpackage

/* sv/bss_cell.sv */
module bss_cell
    import bss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  logic [7:0] i_pat_src,
    input  logic       i_act_src,
    input  logic [7:0] i_txt_src,
    output logic [7:0] o_pat,
    output logic       o_act,
    output logic [7:0] o_txt,
    output logic       o_eq
);

    // Each cell holds one pattern byte, its active bit and one window byte.
    logic [7:0] r_pat;
    logic [7:0] n_pat;
    logic       r_act;
    logic       n_act;
    logic [7:0] r_txt;
    logic [7:0] n_txt;

    always_comb begin
        n_pat = i_ctrl.pat_shift ? i_pat_src : r_pat;
        n_txt = i_ctrl.txt_shift ? i_txt_src : r_txt;
        if (i_ctrl.pat_shift) begin
            n_act = i_act_src;
        end else if (i_ctrl.clr) begin
            n_act = 1'b0;
        end else begin
            n_act = r_act;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pat <= n_pat;
        r_txt <= n_txt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else begin
            r_act <= n_act;
        end
    end

    // The comparison uses the window byte that arrives with this request.
    assign o_eq  = !r_act || (i_txt_src == r_pat);
    assign o_pat = r_pat;
    assign o_act = r_act;
    assign o_txt = r_txt;

endmodule

/* sv/bss_out_buf.sv */
module bss_out_buf
    import bss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rsp i_data,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_data
);

    logic r_main_valid;
    logic n_main_valid;
    logic r_skid_valid;
    logic n_skid_valid;
    t_rsp r_main;
    t_rsp n_main;
    t_rsp r_skid;
    t_rsp n_skid;
    logic pop;

    assign pop = r_main_valid && i_ready;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (i_push) begin
            if (!r_main_valid || pop) begin
                n_main       = i_data;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end else if (pop) begin
            n_main       = r_skid;
            n_main_valid = r_skid_valid;
            n_skid_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

endmodule

/* sv/bounded_substring_search.sv */
// Accepts one pattern or text byte per cycle while o_req_ready is high.
// A text byte marked last pushes its result into the registered output buffer.
// The window comparison across the row of cells is done in the accepting cycle.
// A two-entry output buffer keeps o_req_ready high unless two results wait unread.
// Synchronous active-low reset clears all control state; stored bytes are not reset.
module bounded_substring_search
    import bss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    logic                  r_in_text;
    logic                  n_in_text;
    logic                  r_pat_done;
    logic                  n_pat_done;
    logic                  r_pat_nul;
    logic                  n_pat_nul;
    logic                  r_overflow;
    logic                  n_overflow;
    logic [PAT_LEN_W-1:0]  r_pat_len;
    logic [PAT_LEN_W-1:0]  n_pat_len;
    logic [TEXT_POS_W-1:0] r_text_pos;
    logic [TEXT_POS_W-1:0] n_text_pos;
    logic                  r_match_seen;
    logic                  n_match_seen;
    logic [INDEX_W-1:0]    r_match_start;
    logic [INDEX_W-1:0]    n_match_start;

    logic                  req_fire;
    logic                  pat_fire;
    logic                  txt_fire;
    logic                  eff_nul;
    logic                  eff_overflow;
    logic [PAT_LEN_W-1:0]  eff_len;
    logic [TEXT_POS_W-1:0] pos_new;
    logic [TEXT_POS_W-1:0] start_full;
    logic                  win_hit;
    logic                  seen_new;
    logic [INDEX_W-1:0]    start_new;
    logic                  hit;
    logic                  rsp_push;
    t_rsp                  rsp_data;
    t_cell_ctrl            ctrl;

    logic [PATTERN_MAX-1:0][7:0] cell_pat;
    logic [PATTERN_MAX-1:0]      cell_act;
    logic [PATTERN_MAX-1:0][7:0] cell_txt;
    logic [PATTERN_MAX-1:0]      cell_eq;

    assign req_fire = i_req_valid && o_req_ready;
    assign pat_fire = req_fire && (t_func'(i_req.func) == FUNC_PATTERN);
    assign txt_fire = req_fire && (t_func'(i_req.func) == FUNC_TEXT);

    assign ctrl.clr = pat_fire && (r_in_text || r_pat_done);

    assign eff_nul      = ctrl.clr ? 1'b0 : r_pat_nul;
    assign eff_overflow = ctrl.clr ? 1'b0 : r_overflow;
    assign eff_len      = ctrl.clr ? '0 : r_pat_len;

    assign ctrl.pat_shift = pat_fire && (i_req.data_byte != 8'd0) && !eff_nul
                            && (eff_len < PAT_LEN_W'(PATTERN_MAX));
    assign ctrl.txt_shift = txt_fire && (r_text_pos < TEXT_POS_W'(TEXT_MAX));

    genvar j;
    generate
        for (j = 0; j < PATTERN_MAX; j++) begin : g_cell
            logic [7:0] pat_src;
            logic       act_src;
            logic [7:0] txt_src;
            if (j == PATTERN_MAX - 1) begin : g_head
                assign pat_src = i_req.data_byte;
                assign act_src = 1'b1;
                assign txt_src = i_req.data_byte;
            end else begin : g_body
                assign pat_src = cell_pat[j+1];
                assign act_src = cell_act[j+1] && !ctrl.clr;
                assign txt_src = cell_txt[j+1];
            end
            bss_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (ctrl),
                .i_pat_src (pat_src),
                .i_act_src (act_src),
                .i_txt_src (txt_src),
                .o_pat     (cell_pat[j]),
                .o_act     (cell_act[j]),
                .o_txt     (cell_txt[j]),
                .o_eq      (cell_eq[j])
            );
        end
    endgenerate

    assign pos_new    = r_text_pos + TEXT_POS_W'(1);
    assign start_full = pos_new - TEXT_POS_W'(r_pat_len);
    assign win_hit    = (r_pat_len != '0) && (pos_new >= TEXT_POS_W'(r_pat_len)) && (&cell_eq);
    assign seen_new   = r_match_seen || (ctrl.txt_shift && win_hit);
    assign start_new  = r_match_seen ? r_match_start : start_full[INDEX_W-1:0];
    assign hit        = seen_new && (r_pat_len != '0) && !r_overflow;

    assign rsp_push                  = txt_fire && i_req.is_last;
    assign rsp_data.found            = hit;
    assign rsp_data.start_index      = hit ? start_new : '0;
    assign rsp_data.pattern_overflow = r_overflow;

    always_comb begin
        n_in_text     = r_in_text;
        n_pat_done    = r_pat_done;
        n_pat_nul     = r_pat_nul;
        n_overflow    = r_overflow;
        n_pat_len     = r_pat_len;
        n_text_pos    = r_text_pos;
        n_match_seen  = r_match_seen;
        n_match_start = r_match_start;
        if (pat_fire) begin
            n_in_text  = 1'b0;
            n_pat_done = (ctrl.clr ? 1'b0 : r_pat_done) || i_req.is_last;
            n_pat_nul  = eff_nul || (i_req.data_byte == 8'd0);
            n_overflow = eff_overflow || ((i_req.data_byte != 8'd0) && !eff_nul
                         && (eff_len == PAT_LEN_W'(PATTERN_MAX)));
            n_pat_len  = ctrl.pat_shift ? eff_len + PAT_LEN_W'(1) : eff_len;
            if (ctrl.clr) begin
                n_text_pos    = '0;
                n_match_seen  = 1'b0;
                n_match_start = '0;
            end
        end else if (txt_fire) begin
            n_in_text = 1'b1;
            if (i_req.is_last) begin
                n_text_pos    = '0;
                n_match_seen  = 1'b0;
                n_match_start = '0;
            end else if (ctrl.txt_shift) begin
                n_text_pos    = pos_new;
                n_match_seen  = seen_new;
                n_match_start = start_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_text     <= 1'b0;
            r_pat_done    <= 1'b0;
            r_pat_nul     <= 1'b0;
            r_overflow    <= 1'b0;
            r_pat_len     <= '0;
            r_text_pos    <= '0;
            r_match_seen  <= 1'b0;
            r_match_start <= '0;
        end else begin
            r_in_text     <= n_in_text;
            r_pat_done    <= n_pat_done;
            r_pat_nul     <= n_pat_nul;
            r_overflow    <= n_overflow;
            r_pat_len     <= n_pat_len;
            r_text_pos    <= n_text_pos;
            r_match_seen  <= n_match_seen;
            r_match_start <= n_match_start;
        end
    end

    bss_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rsp_push),
        .i_data  (rsp_data),
        .o_ready (o_req_ready),
        .o_valid (o_rsp_valid),
        .i_ready (i_rsp_ready),
        .o_data  (o_rsp)
    );

endmodule

/* sv/bss_checker.sv */
module bss_checker
    import bss_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_req_ready,
    input logic o_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp o_rsp
);

    a_found_excludes_overflow: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !(o_rsp.found && o_rsp.pattern_overflow)
    ) else $error("result reports a match with an overflowed pattern");

    a_index_zero_when_missed: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.found) |-> (o_rsp.start_index == '0)
    ) else $error("start index is not zero on a miss");

    a_stall_needs_pending: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_req_ready |-> o_rsp_valid
    ) else $error("request side stalled with no result pending");

    a_quiet_after_reset: assert property (
        @(posedge i_clk)
        $past(!i_rst_n) |-> (!o_rsp_valid && o_req_ready)
    ) else $error("handshake outputs not idle after reset");

    a_rsp_held: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !i_rsp_ready) |=> (o_rsp_valid && $stable(o_rsp))
    ) else $error("result changed while stalled");

endmodule

bind bounded_substring_search bss_checker u_bss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_req_ready (o_req_ready),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);

/* dv/testbench.sv */
import bss_pkg::*;

typedef logic [7:0] t_bytes [$];

class search_scoreboard;
    logic [7:0]  pat_bytes [PATTERN_MAX];
    int unsigned pat_len;
    bit          pat_ovf;
    bit          in_text;
    bit          pat_nul;
    bit          pat_done;
    logic [7:0]  window [PATTERN_MAX];
    int unsigned text_pos;
    bit          hit_seen;
    int unsigned hit_start;
    t_rsp        expected_results [$];
    int          predicted;
    int          checked;
    int          errors;

    function new();
        predicted = 0;
        checked   = 0;
        errors    = 0;
        foreach (pat_bytes[i]) pat_bytes[i] = '0;
        clear_job();
    endfunction

    function void clear_text();
        foreach (window[i]) window[i] = '0;
        text_pos  = 0;
        hit_seen  = 1'b0;
        hit_start = 0;
    endfunction

    function void clear_job();
        pat_len  = 0;
        pat_ovf  = 1'b0;
        in_text  = 1'b0;
        pat_nul  = 1'b0;
        pat_done = 1'b0;
        clear_text();
    endfunction

    // The newest pat_len bytes of the window sit at its top end.
    function bit window_hit();
        int unsigned base;
        if (pat_len == 0 || text_pos < pat_len) return 1'b0;
        base = PATTERN_MAX - pat_len;
        for (int k = 0; k < pat_len; k++) begin
            if (window[base + k] != pat_bytes[k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function void apply_request(t_req r);
        t_rsp want;
        bit   hit;
        if (r.func == FUNC_PATTERN) begin
            if (in_text || pat_done) clear_job();
            if (r.data_byte == 8'd0) begin
                pat_nul = 1'b1;
            end else if (!pat_nul) begin
                if (pat_len < PATTERN_MAX) begin
                    pat_bytes[pat_len] = r.data_byte;
                    pat_len++;
                end else begin
                    pat_ovf = 1'b1;
                end
            end
            if (r.is_last) pat_done = 1'b1;
            return;
        end
        in_text = 1'b1;
        if (text_pos < TEXT_MAX) begin
            for (int i = 0; i < PATTERN_MAX - 1; i++) window[i] = window[i + 1];
            window[PATTERN_MAX - 1] = r.data_byte;
            text_pos++;
            if (!hit_seen && window_hit()) begin
                hit_seen  = 1'b1;
                hit_start = text_pos - pat_len;
            end
        end
        if (r.is_last) begin
            hit                   = hit_seen && pat_len > 0 && !pat_ovf;
            want.found            = hit;
            want.start_index      = hit ? INDEX_W'(hit_start) : '0;
            want.pattern_overflow = pat_ovf;
            expected_results.push_back(want);
            predicted++;
            clear_text();
        end
    endfunction

    task report(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    task check_result(t_rsp got);
        t_rsp want;
        if (expected_results.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
        end
        want = expected_results.pop_front();
        checked++;
        if (got.found !== want.found)
            report($sformatf("result %0d: found %b, expected %b",
                             checked, got.found, want.found));
        if (got.start_index !== want.start_index)
            report($sformatf("result %0d: start_index %0d, expected %0d",
                             checked, got.start_index, want.start_index));
        if (got.pattern_overflow !== want.pattern_overflow)
            report($sformatf("result %0d: pattern_overflow %b, expected %b",
                             checked, got.pattern_overflow, want.pattern_overflow));
    endtask
endclass

module testbench;

    localparam int unsigned CYCLE_LIMIT = 600000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    t_req req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    t_rsp rsp;

    bit          idle_on    = 1'b1;
    int          stall_left = 0;
    int unsigned cycles     = 0;
    int unsigned sent       = 0;

    search_scoreboard sb = new();

    bounded_substring_search u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin : rsp_stall
        int next_stall;
        next_stall = stall_left;
        if (next_stall != 0) next_stall--;
        else if (idle_on && $urandom_range(0, 7) == 0) next_stall = $urandom_range(1, 19);
        stall_left <= next_stall;
        rsp_ready  <= (next_stall == 0);
    end

    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready) sb.check_result(rsp);
    end

    function automatic t_bytes str_bytes(string s);
        t_bytes q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    function automatic logic [7:0] rand_byte(bit wide);
        return wide ? 8'($urandom_range(0, 255)) : 8'(8'h61 + $urandom_range(0, 2));
    endfunction

    task automatic send_req(input t_func f, input logic [7:0] b, input logic last);
        t_req r;
        r.func      = f;
        r.data_byte = b;
        r.is_last   = last;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
        sb.apply_request(r);
        sent++;
    endtask

    task automatic send_bytes(input t_func f, input t_bytes q, input bit mark_last);
        for (int i = 0; i < q.size(); i++)
            send_req(f, q[i], mark_last && i == q.size() - 1);
    endtask

    // The match is placed so that it ends on the last counted text byte or just past it.
    task automatic send_long_text(input int unsigned at);
        logic [7:0] b;
        for (int unsigned i = 0; i < TEXT_MAX + 2; i++) begin
            b = (i == at) ? 8'h41 : (i == at + 1) ? 8'h42 : 8'h78;
            send_req(FUNC_TEXT, b, i == TEXT_MAX + 1);
        end
    endtask

    initial begin
        t_bytes      pat;
        t_bytes      cur_pat;
        t_bytes      txt;
        int          plen;
        int          tlen;
        int          pos;
        bit          wide;
        int unsigned random_start;
        int          pred_start;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_bytes(FUNC_TEXT, str_bytes("ab"), 1'b1);
        send_bytes(FUNC_PATTERN, '{8'hFF, 8'h01}, 1'b1);
        send_bytes(FUNC_TEXT, '{8'h00, 8'hFF, 8'h01}, 1'b1);
        send_bytes(FUNC_TEXT, '{8'h01}, 1'b1);
        send_bytes(FUNC_PATTERN, '{8'h71, 8'h00, 8'h72}, 1'b1);
        send_bytes(FUNC_TEXT, str_bytes("xq"), 1'b1);
        for (int i = 0; i <= PATTERN_MAX; i++) send_req(FUNC_PATTERN, 8'h7A, i == PATTERN_MAX);
        send_bytes(FUNC_TEXT, str_bytes("zz"), 1'b1);
        send_req(FUNC_PATTERN, 8'h63, 1'b0);
        send_req(FUNC_TEXT, 8'h63, 1'b1);
        send_req(FUNC_PATTERN, 8'h00, 1'b1);
        send_req(FUNC_TEXT, 8'h64, 1'b1);

        idle_on = 1'b0;
        send_bytes(FUNC_PATTERN, str_bytes("AB"), 1'b1);
        send_long_text(TEXT_MAX - 2);
        send_long_text(TEXT_MAX - 1);

        random_start = sent;
        pred_start   = sb.predicted;
        while (sent - random_start < 650 || sb.predicted - pred_start < 40) begin
            idle_on = (sent - random_start < 520) && ($urandom_range(0, 3) != 0);
            wide    = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) != 0) begin
                pat  = {};
                plen = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 18)
                                                   : $urandom_range(1, 4);
                for (int i = 0; i < plen; i++) pat.push_back(rand_byte(wide));
                if ($urandom_range(0, 7) == 0) pat[$urandom_range(0, plen - 1)] = 8'h00;
                send_bytes(FUNC_PATTERN, pat, $urandom_range(0, 7) != 0);
                cur_pat = {};
                foreach (pat[i]) begin
                    if (pat[i] == 8'h00) break;
                    if (cur_pat.size() < PATTERN_MAX) cur_pat.push_back(pat[i]);
                end
            end
            if ($urandom_range(0, 11) == 0)
                send_req(t_func'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 3)) begin
                tlen = $urandom_range(1, cur_pat.size() + 12);
                txt  = {};
                for (int i = 0; i < tlen; i++) txt.push_back(rand_byte(wide));
                if (cur_pat.size() != 0 && tlen >= cur_pat.size() && $urandom_range(0, 1)) begin
                    pos = $urandom_range(0, tlen - cur_pat.size());
                    foreach (cur_pat[k]) txt[pos + k] = cur_pat[k];
                end
                send_bytes(FUNC_TEXT, txt, $urandom_range(0, 9) != 0);
            end
        end
        idle_on = 1'b0;
        req_valid <= 1'b0;

        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/bss_pkg.sv
sv/bss_cell.sv
sv/bss_out_buf.sv
sv/bounded_substring_search.sv
sv/bss_checker.sv
dv/testbench.sv
